@@ rtl/mdst_pkg.sv @@
// Shared payload types and constants for the max-degree-first spanning tree block.
package mdst_pkg;

   localparam int VERTEX_BITS = 6;
   localparam int WEIGHT_BITS = 32;
   localparam int CFG_BITS    = 7;

   typedef struct packed {
      logic [VERTEX_BITS-1:0]        edge_from;
      logic [VERTEX_BITS-1:0]        edge_to;
      logic signed [WEIGHT_BITS-1:0] edge_weight;
      logic                          edge_present;
      logic                          last_edge;
   } req_type;

   typedef struct packed {
      logic [VERTEX_BITS-1:0]        tree_from;
      logic [VERTEX_BITS-1:0]        tree_to;
      logic signed [WEIGHT_BITS-1:0] tree_weight;
      logic                          tree_edge_valid;
      logic                          last_result;
      logic                          edges_dropped;
   } rsp_type;

   typedef struct packed {
      logic [VERTEX_BITS-1:0]        from_v;
      logic [VERTEX_BITS-1:0]        to_v;
      logic signed [WEIGHT_BITS-1:0] weight;
   } edge_type;

endpackage

@@ rtl/mdst_core.sv @@
// Edge store, rank sort, degree count and label-based union-find sequencer.
module mdst_core
   import mdst_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CFG_BITS-1:0] vertex_count,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int VCW = $clog2(MAX_VERTICES + 1);
   localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int DW  = ECW + 1;
   localparam int NW  = (VCW > CFG_BITS) ? VCW : CFG_BITS;

   typedef enum logic [9:0] {
      ST_LOAD    = 10'b00_0000_0001,
      ST_CLEAR   = 10'b00_0000_0010,
      ST_SORT_E  = 10'b00_0000_0100,
      ST_SORT_J  = 10'b00_0000_1000,
      ST_SORT_W  = 10'b00_0001_0000,
      ST_DEGREE  = 10'b00_0010_0000,
      ST_BEST    = 10'b00_0100_0000,
      ST_KRUSKAL = 10'b00_1000_0000,
      ST_RELABEL = 10'b01_0000_0000,
      ST_EMIT    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0]      ph_ff, ph_in;
   logic [ECW-1:0]  total_ff, total_in;
   logic            drop_ff, drop_in;
   logic [ECW-1:0]  e_ff, e_in;
   logic [ECW-1:0]  j_ff, j_in;
   logic [ECW-1:0]  rank_ff, rank_in;
   logic [ECW-1:0]  kcnt_ff, kcnt_in;
   edge_type        ent_ff, ent_in;
   logic            ekeep_ff, ekeep_in;
   logic [VCW-1:0]  v_ff, v_in;
   logic [VW-1:0]   best_ff, best_in;
   logic [DW-1:0]   bestdeg_ff, bestdeg_in;
   logic [VW-1:0]   la_ff, la_in;
   logic [VW-1:0]   lb_ff, lb_in;
   logic            pass_ff, pass_in;
   logic [VCW-1:0]  acnt_ff, acnt_in;
   rsp_type         out_ff, out_in;
   logic            out_v_ff, out_v_in;

   edge_type edge_mem [MAX_EDGES];
   edge_type order_mem [MAX_EDGES];
   logic [DW-1:0] deg_mem [MAX_VERTICES];
   logic [VW-1:0] lab_mem [MAX_VERTICES];
   edge_type acc_mem [MAX_VERTICES];

   logic           edge_we, order_we, deg_we, lab_we, acc_we;
   logic [EIW-1:0] edge_waddr, edge_raddr, order_waddr, order_raddr;
   logic [VW-1:0]  deg_waddr, deg_raddr, lab_waddr, lab_raddr, acc_waddr, acc_raddr;
   edge_type       edge_wdata, order_wdata, acc_wdata;
   logic [DW-1:0]  deg_wdata;
   logic [VW-1:0]  lab_wdata;
   edge_type       edge_rd_ff, order_rd_ff, acc_rd_ff;
   logic [DW-1:0]  deg_rd_ff;
   logic [VW-1:0]  lab_rd_ff;

   logic [NW-1:0]  n_eff;
   logic           req_fit, rd_keep, rank_hit, out_free;

   assign n_eff = (NW'(vertex_count) < NW'(MAX_VERTICES)) ? NW'(vertex_count)
                                                          : NW'(MAX_VERTICES);
   assign req_fit = (NW'(req_data.edge_from) < n_eff) && (NW'(req_data.edge_to) < n_eff)
                    && (total_ff < ECW'(MAX_EDGES));
   assign rd_keep = (NW'(edge_rd_ff.from_v) < n_eff) && (NW'(edge_rd_ff.to_v) < n_eff);
   assign rank_hit = rd_keep &&
                     (($signed(edge_rd_ff.weight) > $signed(ent_ff.weight)) ||
                      ((edge_rd_ff.weight == ent_ff.weight) && (j_ff < e_ff)));
   assign out_free = !out_v_ff || rsp_ready;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in   = state_ff;
      ph_in      = ph_ff;
      total_in   = total_ff;
      drop_in    = drop_ff;
      e_in       = e_ff;
      j_in       = j_ff;
      rank_in    = rank_ff;
      kcnt_in    = kcnt_ff;
      ent_in     = ent_ff;
      ekeep_in   = ekeep_ff;
      v_in       = v_ff;
      best_in    = best_ff;
      bestdeg_in = bestdeg_ff;
      la_in      = la_ff;
      lb_in      = lb_ff;
      pass_in    = pass_ff;
      acnt_in    = acnt_ff;
      out_in     = out_ff;
      out_v_in   = out_v_ff && !rsp_ready;
      edge_we = 1'b0;  edge_waddr = '0;  edge_wdata = '0;  edge_raddr = '0;
      order_we = 1'b0; order_waddr = '0; order_wdata = '0; order_raddr = '0;
      deg_we = 1'b0;   deg_waddr = '0;   deg_wdata = '0;   deg_raddr = '0;
      lab_we = 1'b0;   lab_waddr = '0;   lab_wdata = '0;   lab_raddr = '0;
      acc_we = 1'b0;   acc_waddr = '0;   acc_wdata = '0;   acc_raddr = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (req_data.edge_present) begin
                  if (req_fit) begin
                     edge_we    = 1'b1;
                     edge_waddr = total_ff[EIW-1:0];
                     edge_wdata = '{req_data.edge_from, req_data.edge_to,
                                    req_data.edge_weight};
                     total_in   = total_ff + ECW'(1);
                  end else begin
                     drop_in = 1'b1;
                  end
               end
               if (req_data.last_edge) begin
                  state_in = ST_CLEAR;
                  v_in     = '0;
               end
            end
         end
         ST_CLEAR: begin
            // reset degrees and give every vertex its own label
            deg_we    = 1'b1;
            deg_waddr = VW'(v_ff);
            deg_wdata = '0;
            lab_we    = 1'b1;
            lab_waddr = VW'(v_ff);
            lab_wdata = VW'(v_ff);
            v_in      = v_ff + VCW'(1);
            if (v_ff == VCW'(MAX_VERTICES - 1)) begin
               state_in = ST_SORT_E;
               e_in     = '0;
               rank_in  = '0;
               kcnt_in  = '0;
               acnt_in  = '0;
               ph_in    = '0;
            end
         end
         ST_SORT_E: begin
            if (e_ff == total_ff) begin
               state_in = ST_DEGREE;
               j_in     = '0;
               ph_in    = '0;
            end else if (ph_ff == 3'd0) begin
               edge_raddr = e_ff[EIW-1:0];
               ph_in      = 3'd1;
            end else begin
               ent_in   = edge_rd_ff;
               ekeep_in = rd_keep;
               j_in     = '0;
               ph_in    = '0;
               state_in = ST_SORT_J;
            end
         end
         ST_SORT_J: begin
            // count kept edges that precede this one in stable descending order
            if (ph_ff == 3'd0) begin
               edge_raddr = j_ff[EIW-1:0];
               ph_in      = 3'd1;
            end else begin
               if (rank_hit) rank_in = rank_ff + ECW'(1);
               j_in  = j_ff + ECW'(1);
               ph_in = '0;
               if (j_ff == total_ff - ECW'(1)) state_in = ST_SORT_W;
            end
         end
         ST_SORT_W: begin
            if (ekeep_ff) begin
               order_we    = 1'b1;
               order_waddr = rank_ff[EIW-1:0];
               order_wdata = ent_ff;
               kcnt_in     = kcnt_ff + ECW'(1);
            end else begin
               drop_in = 1'b1;
            end
            e_in     = e_ff + ECW'(1);
            rank_in  = '0;
            ph_in    = '0;
            state_in = ST_SORT_E;
         end
         ST_DEGREE: begin
            if (j_ff == kcnt_ff) begin
               state_in = ST_BEST;
               v_in     = '0;
               ph_in    = '0;
            end else begin
               unique case (ph_ff)
                  3'd0: begin
                     order_raddr = j_ff[EIW-1:0];
                     ph_in       = 3'd1;
                  end
                  3'd1: begin
                     ent_in    = order_rd_ff;
                     deg_raddr = VW'(order_rd_ff.from_v);
                     ph_in     = 3'd2;
                  end
                  3'd2: begin
                     deg_we    = 1'b1;
                     deg_waddr = VW'(ent_ff.from_v);
                     deg_wdata = deg_rd_ff + DW'(1);
                     ph_in     = 3'd3;
                  end
                  3'd3: begin
                     deg_raddr = VW'(ent_ff.to_v);
                     ph_in     = 3'd4;
                  end
                  3'd4: begin
                     deg_we    = 1'b1;
                     deg_waddr = VW'(ent_ff.to_v);
                     deg_wdata = deg_rd_ff + DW'(1);
                     j_in      = j_ff + ECW'(1);
                     ph_in     = '0;
                  end
                  default: ph_in = '0;
               endcase
            end
         end
         ST_BEST: begin
            if (NW'(v_ff) >= n_eff) begin
               state_in = ST_KRUSKAL;
               j_in     = '0;
               pass_in  = 1'b0;
               ph_in    = '0;
            end else if (ph_ff == 3'd0) begin
               deg_raddr = VW'(v_ff);
               ph_in     = 3'd1;
            end else begin
               if ((v_ff == '0) || (deg_rd_ff > bestdeg_ff)) begin
                  best_in    = VW'(v_ff);
                  bestdeg_in = deg_rd_ff;
               end
               v_in  = v_ff + VCW'(1);
               ph_in = '0;
            end
         end
         ST_KRUSKAL: begin
            if (j_ff == kcnt_ff) begin
               j_in  = '0;
               ph_in = '0;
               if (!pass_ff) begin
                  pass_in = 1'b1;
               end else begin
                  state_in = ST_EMIT;
                  v_in     = '0;
               end
            end else begin
               unique case (ph_ff)
                  3'd0: begin
                     order_raddr = j_ff[EIW-1:0];
                     ph_in       = 3'd1;
                  end
                  3'd1: begin
                     ent_in = order_rd_ff;
                     // first pass only looks at edges on the busiest vertex
                     if (!pass_ff && (VW'(order_rd_ff.from_v) != best_ff)
                         && (VW'(order_rd_ff.to_v) != best_ff)) begin
                        j_in  = j_ff + ECW'(1);
                        ph_in = '0;
                     end else begin
                        lab_raddr = VW'(order_rd_ff.from_v);
                        ph_in     = 3'd2;
                     end
                  end
                  3'd2: begin
                     la_in     = lab_rd_ff;
                     lab_raddr = VW'(ent_ff.to_v);
                     ph_in     = 3'd3;
                  end
                  3'd3: begin
                     j_in  = j_ff + ECW'(1);
                     ph_in = '0;
                     if (lab_rd_ff != la_ff) begin
                        lb_in     = lab_rd_ff;
                        acc_we    = 1'b1;
                        acc_waddr = VW'(acnt_ff);
                        acc_wdata = ent_ff;
                        acnt_in   = acnt_ff + VCW'(1);
                        v_in      = '0;
                        state_in  = ST_RELABEL;
                     end
                  end
                  default: ph_in = '0;
               endcase
            end
         end
         ST_RELABEL: begin
            // merge: move every vertex of the second set into the first
            if (NW'(v_ff) >= n_eff) begin
               state_in = ST_KRUSKAL;
               ph_in    = '0;
            end else if (ph_ff == 3'd0) begin
               lab_raddr = VW'(v_ff);
               ph_in     = 3'd1;
            end else begin
               if (lab_rd_ff == lb_ff) begin
                  lab_we    = 1'b1;
                  lab_waddr = VW'(v_ff);
                  lab_wdata = la_ff;
               end
               v_in  = v_ff + VCW'(1);
               ph_in = '0;
            end
         end
         ST_EMIT: begin
            if (acnt_ff == '0) begin
               if (out_free) begin
                  out_in   = '{'0, '0, '0, 1'b0, 1'b1, drop_ff};
                  out_v_in = 1'b1;
                  total_in = '0;
                  drop_in  = 1'b0;
                  state_in = ST_LOAD;
               end
            end else if (ph_ff == 3'd0) begin
               acc_raddr = VW'(v_ff);
               ph_in     = 3'd1;
            end else begin
               // hold the read address so the entry stays put while the output waits
               acc_raddr = VW'(v_ff);
               if (out_free) begin
                  out_in   = '{acc_rd_ff.from_v, acc_rd_ff.to_v, acc_rd_ff.weight, 1'b1,
                               (v_ff + VCW'(1) == acnt_ff), drop_ff};
                  out_v_in = 1'b1;
                  v_in     = v_ff + VCW'(1);
                  ph_in    = '0;
                  if (v_ff + VCW'(1) == acnt_ff) begin
                     total_in = '0;
                     drop_in  = 1'b0;
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
      edge_rd_ff <= edge_mem[edge_raddr];
   end

   always_ff @(posedge clock) begin
      if (order_we) order_mem[order_waddr] <= order_wdata;
      order_rd_ff <= order_mem[order_raddr];
   end

   always_ff @(posedge clock) begin
      if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
      deg_rd_ff <= deg_mem[deg_raddr];
   end

   always_ff @(posedge clock) begin
      if (lab_we) lab_mem[lab_waddr] <= lab_wdata;
      lab_rd_ff <= lab_mem[lab_raddr];
   end

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
      acc_rd_ff <= acc_mem[acc_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         ph_ff    <= '0;
         total_ff <= '0;
         drop_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         total_ff <= total_in;
         drop_ff  <= drop_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff       <= e_in;
      j_ff       <= j_in;
      rank_ff    <= rank_in;
      kcnt_ff    <= kcnt_in;
      ent_ff     <= ent_in;
      ekeep_ff   <= ekeep_in;
      v_ff       <= v_in;
      best_ff    <= best_in;
      bestdeg_ff <= bestdeg_in;
      la_ff      <= la_in;
      lb_ff      <= lb_in;
      pass_ff    <= pass_in;
      acnt_ff    <= acnt_in;
      out_ff     <= out_in;
   end

endmodule

@@ rtl/max_degree_first_spanning_tree.sv @@
// Edge beats load while req_ready is high; req_ready drops from the last edge until the run ends.
// A run clears the degree and label memories, rank-sorts the stored edges, counts degrees,
// finds the busiest vertex, runs two Kruskal passes with a relabel per tree edge, and emits
// the tree edges, or one empty beat for an empty tree. Results leave through an output
// register; the next graph loads while the last one waits. Reset (synchronous, active high)
// empties the store.
module max_degree_first_spanning_tree
   import mdst_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic              REG_VERTEX_COUNT   = 1'b0;
   localparam logic [CFG_BITS-1:0] VERTEX_COUNT_RESET = 7'd64;

   logic [CFG_BITS-1:0] vertex_count_ff, vertex_count_in;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
   assign vertex_count_in = csr_write ? pwdata[CFG_BITS-1:0] : vertex_count_ff;
   assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {25'd0, vertex_count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RESET;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   mdst_core #(
      .MAX_VERTICES(MAX_VERTICES),
      .MAX_EDGES   (MAX_EDGES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .vertex_count(vertex_count_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.tree_edge_valid |-> rsp_data.last_result)
      else $error("empty-tree beat without last_result");

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.tree_edge_valid |->
         (rsp_data.tree_weight == '0) && (rsp_data.tree_from == '0))
      else $error("empty-tree beat carries edge data");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> vertex_count_ff == $past(pwdata[CFG_BITS-1:0]))
      else $error("vertex_count write lost");
`endif

endmodule

@@ tb/sv/tb_max_degree_first_spanning_tree.sv @@
// Testbench for the max-degree-first spanning tree block: directed and random graphs checked against a predictor.
`timescale 1ns / 1ps

module tb_max_degree_first_spanning_tree;
   import mdst_pkg::*;

   localparam int NV_MAX   = 64;
   localparam int EDGE_CAP = 256;
   localparam logic [2:0] VERTEX_COUNT_ADDR = 3'd0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   max_degree_first_spanning_tree u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [5:0]         st_from [EDGE_CAP];
   logic [5:0]         st_to [EDGE_CAP];
   logic signed [31:0] st_w [EDGE_CAP];
   int                 stored_edges = 0;
   bit                 lost_edge = 0;
   int                 cfg_vertices = 64;
   int                 uf_parent [NV_MAX];

   req_type edge_q [$];
   rsp_type tree_q [$];
   int      errors = 0;
   int      items_queued = 0;
   int      send_gap = 0;
   int      recv_gap = 0;
   bit      quiet = 0;
   bit      hold_rsp = 0;

   task automatic report(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
   endtask

   function automatic int uf_root(input int x);
      while (uf_parent[x] != x) x = uf_parent[x];
      return x;
   endfunction

   // Kruskal over the stored edges, heaviest first, hub vertex edges first
   function automatic void predict_tree(input req_type r);
      int n, k, best, e, j, ra, rb;
      int order [$];
      int degree [NV_MAX];
      int picked [$];
      rsp_type t;
      n = (cfg_vertices < NV_MAX) ? cfg_vertices : NV_MAX;
      if (r.edge_present) begin
         if (r.edge_from >= n || r.edge_to >= n || stored_edges >= EDGE_CAP) lost_edge = 1;
         else begin
            st_from[stored_edges] = r.edge_from;
            st_to[stored_edges] = r.edge_to;
            st_w[stored_edges] = r.edge_weight;
            stored_edges++;
         end
      end
      if (!r.last_edge) return;
      for (int i = 0; i < stored_edges; i++) begin
         if (st_from[i] >= n || st_to[i] >= n) lost_edge = 1;
         else order = {order, i};
      end
      k = order.size();
      for (int i = 1; i < k; i++) begin
         e = order[i];
         j = i;
         while (j > 0 && st_w[order[j-1]] < st_w[e]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = e;
      end
      for (int i = 0; i < NV_MAX; i++) begin
         degree[i] = 0;
         uf_parent[i] = i;
      end
      for (int i = 0; i < k; i++) begin
         degree[st_from[order[i]]]++;
         degree[st_to[order[i]]]++;
      end
      best = 0;
      for (int i = 1; i < n; i++) if (degree[i] > degree[best]) best = i;
      for (int pass = 0; pass < 2; pass++)
         for (int i = 0; i < k; i++) begin
            e = order[i];
            if (pass == 0 && st_from[e] != best && st_to[e] != best) continue;
            ra = uf_root(st_from[e]);
            rb = uf_root(st_to[e]);
            if (ra != rb) begin
               picked = {picked, e};
               uf_parent[rb] = ra;
            end
         end
      if (picked.size() == 0) begin
         t = '0;
         t.last_result = 1'b1;
         t.edges_dropped = lost_edge;
         tree_q = {tree_q, t};
      end
      foreach (picked[i]) begin
         t.tree_from = st_from[picked[i]];
         t.tree_to = st_to[picked[i]];
         t.tree_weight = st_w[picked[i]];
         t.tree_edge_valid = 1'b1;
         t.last_result = (i == picked.size() - 1);
         t.edges_dropped = lost_edge;
         tree_q = {tree_q, t};
      end
      stored_edges = 0;
      lost_edge = 0;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) predict_tree(req_data);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (edge_q.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= edge_q.pop_front();
               if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 5);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tree_q.size() == 0) report("result beat with nothing expected");
            else begin
               rsp_type x;
               x = tree_q.pop_front();
               if (rsp_data.tree_from !== x.tree_from)
                  report($sformatf("tree_from %0d, want %0d", rsp_data.tree_from, x.tree_from));
               if (rsp_data.tree_to !== x.tree_to)
                  report($sformatf("tree_to %0d, want %0d", rsp_data.tree_to, x.tree_to));
               if (rsp_data.tree_weight !== x.tree_weight)
                  report($sformatf("tree_weight %0d, want %0d",
                                   rsp_data.tree_weight, x.tree_weight));
               if (rsp_data.tree_edge_valid !== x.tree_edge_valid)
                  report($sformatf("tree_edge_valid %b, want %b",
                                   rsp_data.tree_edge_valid, x.tree_edge_valid));
               if (rsp_data.last_result !== x.last_result)
                  report($sformatf("last_result %b, want %b",
                                   rsp_data.last_result, x.last_result));
               if (rsp_data.edges_dropped !== x.edges_dropped)
                  report($sformatf("edges_dropped %b, want %b",
                                   rsp_data.edges_dropped, x.edges_dropped));
            end
         end
         if (hold_rsp) rsp_ready <= 1'b0;
         else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 6) == 0) begin
            recv_gap <= $urandom_range(0, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic write_vertex_count(input int v);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= VERTEX_COUNT_ADDR;
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cfg_vertices = v & 32'h7f;
   endtask

   task automatic push_item(input int f, input int t, input int w, input bit pres,
                            input bit last);
      req_type r;
      r.edge_from = VERTEX_BITS'(f);
      r.edge_to = VERTEX_BITS'(t);
      r.edge_weight = w;
      r.edge_present = pres;
      r.last_edge = last;
      edge_q = {edge_q, r};
      items_queued++;
   endtask

   function automatic int pick_weight();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 2) - 1;
         1: return 32'h7fffffff;
         2: return 32'h80000000;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_vertex(input int lim);
      if (lim < NV_MAX && $urandom_range(0, 11) == 0) return $urandom_range(lim, 63);
      return $urandom_range(0, lim - 1);
   endfunction

   // one graph of ne edges over vertices mostly below lim, with some noise beats
   task automatic add_graph(input int ne, input int lim);
      bit closer;
      closer = (ne == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ne; i++) begin
         if ($urandom_range(0, 9) == 0) push_item($urandom, $urandom, $urandom, 0, 0);
         push_item(pick_vertex(lim), pick_vertex(lim), pick_weight(), 1,
                   !closer && i == ne - 1);
      end
      if (closer) push_item($urandom, $urandom, $urandom, 0, 1);
   endtask

   // hold until the block has handed back everything expected
   task automatic drain();
      do @(negedge clock);
      while (edge_q.size() != 0 || req_valid || tree_q.size() != 0);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      int lim;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed
      push_item(0, 63, 32'h7fffffff, 1, 1);
      push_item(5, 5, 7, 1, 1);
      push_item(63, 63, 0, 0, 1);
      push_item(1, 2, 3, 1, 0);
      push_item(2, 3, 3, 1, 0);
      push_item(1, 3, 3, 1, 0);
      push_item(3, 4, 32'h80000000, 1, 1);
      drain();
      write_vertex_count(4);
      push_item(0, 7, 9, 1, 0);
      push_item(0, 1, 1, 1, 0);
      push_item(1, 2, 1, 1, 1);
      drain();
      write_vertex_count(64);
      push_item(0, 40, 5, 1, 0);
      push_item(0, 1, 6, 1, 0);
      push_item(1, 2, 7, 1, 0);
      drain();
      write_vertex_count(8);
      push_item(2, 0, -4, 1, 1);
      drain();
      write_vertex_count(0);
      push_item(0, 0, 1, 1, 0);
      push_item(0, 0, 1, 0, 1);
      drain();
      write_vertex_count(127);
      push_item(63, 0, 11, 1, 1);
      drain();
      write_vertex_count(1);
      push_item(0, 0, 2, 1, 1);
      drain();

      // overfill the store once
      write_vertex_count(64);
      for (int i = 0; i < EDGE_CAP + 3; i++)
         push_item($urandom_range(0, 63), $urandom_range(0, 63), pick_weight(), 1,
                   i == EDGE_CAP + 2);
      drain();

      // stall the result side while graphs keep coming
      write_vertex_count(16);
      for (int g = 0; g < 4; g++) add_graph(4, 16);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (700) @(posedge clock);
      hold_rsp <= 1'b0;
      drain();

      // random phases
      while (items_queued < 320) begin
         if (items_queued > 290) quiet = 1;
         case ($urandom_range(0, 4))
            0: lim = 64;
            1: lim = 1;
            2: lim = 127;
            default: lim = $urandom_range(2, 12);
         endcase
         write_vertex_count(lim);
         if (lim > NV_MAX) lim = NV_MAX;
         for (int g = 0; g < 3; g++) add_graph($urandom_range(0, 10), lim);
         drain();
      end

      repeat (100) @(posedge clock);
      if (errors == 0) $display("tb_max_degree_first_spanning_tree OK");
      else $display("tb_max_degree_first_spanning_tree NOT OK");
      $finish;
   end

   initial begin
      #30ms;
      $display("tb_max_degree_first_spanning_tree NOT OK");
      $finish;
   end

endmodule
